// File: rtl/hnm_pkg.sv
// Shared types and constants of the height map normal generator.
// Used by the controller, the datapath and the top level; no dependencies.
package hnm_pkg;

    localparam int HEIGHT_W   = 16;
    localparam int CFG_W      = 11;
    localparam int DIV_STEPS  = 31;
    localparam int SQRT_STEPS = 16;
    localparam int STEP_W     = 5;
    // square of the unit slope term, 512 * 512
    localparam logic [31:0] ONE_SQ = 32'd262144;

    typedef struct packed {
        logic signed [15:0] height;
        logic               flush;
    } t_in;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic        [14:0] normal_z;
        logic        [9:0]  column_out;
        logic        [15:0] row_out;
        logic               last_of_frame;
    } t_out;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RD_LEFT,
        OP_RD_CENTER,
        OP_RD_RIGHT,
        OP_CAP_RIGHT,
        OP_DIFF,
        OP_SQX,
        OP_SQY,
        OP_SUM,
        OP_DIV,
        OP_SQRT,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        first;
        logic        fl;
        logic        sel;
        logic        last;
        logic [15:0] row;
    } t_cmd;

endpackage

// File: rtl/hnm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module hnm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/hnm_ctrl.sv
// Controller: sequencer, raster position counters, row length register, output valid.
// Depends on hnm_pkg; drives hnm_datapath through a command struct.
module hnm_ctrl
    import hnm_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           i_flush,
    output logic                           o_ready,
    output logic                           o_valid,
    input  logic                           i_ready,
    input  logic                           i_cfg_wr_en,
    input  logic [CFG_W-1:0]               i_cfg_wr_data,
    output t_cmd                           o_cmd,
    output logic [$clog2(MAX_WIDTH)-1:0]   o_x,
    output logic [$clog2(MAX_WIDTH+1)-1:0] o_len
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int LW = $clog2(MAX_WIDTH + 1);
    localparam int RESET_LEN = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_LEFT, S_RD_CENTER, S_RD_RIGHT, S_CAP_RIGHT,
        S_DIFF, S_SQX, S_SQY, S_SUM, S_DIV, S_SQRT, S_FIN
    } t_state;

    t_state            r_state, n_state;
    logic [XW-1:0]     r_col, n_col;
    logic [15:0]       r_row, n_row;
    logic              r_sel, n_sel;
    logic              r_flushing, n_flushing;
    logic [LW-1:0]     r_len, n_len;
    logic              r_emit, n_emit;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;

    logic          accept, fl_in, drop, wrap, out_free;
    logic [LW-1:0] col_inc;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign fl_in    = i_flush || r_flushing;
    assign drop     = fl_in && (r_row == 16'd0);
    assign col_inc  = LW'(r_col) + LW'(1);
    assign wrap     = col_inc >= r_len;
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_sel       = r_sel;
        n_flushing  = r_flushing;
        n_len       = r_len;
        n_emit      = r_emit;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '{op: OP_NONE, first: (r_cnt == '0), fl: fl_in, sel: r_sel,
                        last: fl_in && wrap, row: r_row};

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_wr_en) begin
            if (i_cfg_wr_data < CFG_W'(3)) begin
                n_len = LW'(3);
            end else if (32'(i_cfg_wr_data) > 32'(MAX_WIDTH)) begin
                n_len = LW'(MAX_WIDTH);
            end else begin
                n_len = LW'(i_cfg_wr_data);
            end
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (drop) begin
                        // flush with no complete row: back to frame start
                        n_col      = '0;
                        n_row      = '0;
                        n_sel      = 1'b0;
                        n_flushing = 1'b0;
                    end else begin
                        o_cmd.op   = OP_LOAD;
                        n_emit     = fl_in || (r_row != 16'd0);
                        n_flushing = fl_in;
                        n_state    = S_RD_LEFT;
                        if (wrap) begin
                            n_col = '0;
                            if (fl_in) begin
                                n_row      = '0;
                                n_sel      = 1'b0;
                                n_flushing = 1'b0;
                            end else begin
                                n_sel = !r_sel;
                                if (r_row != 16'hFFFF) begin
                                    n_row = r_row + 16'd1;
                                end
                            end
                        end else begin
                            n_col = XW'(col_inc);
                        end
                    end
                end
            end
            S_RD_LEFT: begin
                o_cmd.op = OP_RD_LEFT;
                n_state  = S_RD_CENTER;
            end
            S_RD_CENTER: begin
                o_cmd.op = OP_RD_CENTER;
                n_state  = S_RD_RIGHT;
            end
            S_RD_RIGHT: begin
                o_cmd.op = OP_RD_RIGHT;
                // first row only fills the store
                n_state  = r_emit ? S_CAP_RIGHT : S_IDLE;
            end
            S_CAP_RIGHT: begin
                o_cmd.op = OP_CAP_RIGHT;
                n_state  = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.op = OP_DIFF;
                n_state  = S_SQX;
            end
            S_SQX: begin
                o_cmd.op = OP_SQX;
                n_state  = S_SQY;
            end
            S_SQY: begin
                o_cmd.op = OP_SQY;
                n_state  = S_SUM;
            end
            S_SUM: begin
                o_cmd.op = OP_SUM;
                n_cnt    = '0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                if (r_cnt == STEP_W'(DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_SQRT;
                end else begin
                    n_cnt = r_cnt + STEP_W'(1);
                end
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT;
                if (r_cnt == STEP_W'(SQRT_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + STEP_W'(1);
                end
            end
            S_FIN: begin
                // hold until the output register is free
                if (out_free) begin
                    o_cmd.op    = OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_sel       <= 1'b0;
            r_flushing  <= 1'b0;
            r_len       <= LW'(RESET_LEN);
            r_emit      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_sel       <= n_sel;
            r_flushing  <= n_flushing;
            r_len       <= n_len;
            r_emit      <= n_emit;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_x     = r_col;
    assign o_len   = r_len;

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len >= LW'(3)) && (32'(r_len) <= 32'(MAX_WIDTH)))
        else $error("row length out of range");

    a_flush_has_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flushing |-> (r_row != 16'd0))
        else $error("flushing with no complete row");

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !drop) |=> (r_state == S_RD_LEFT))
        else $error("accepted item did not start");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_OUT) |-> out_free)
        else $error("result overwrote a pending transfer");

endmodule

// File: rtl/hnm_datapath.sv
// Datapath: two row stores, neighbor registers, squares, and three lanes of
// restoring division and square root. Depends on hnm_pkg and hnm_ram.
module hnm_datapath
    import hnm_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           i_clk,
    input  t_cmd                           i_cmd,
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_x,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] i_len,
    input  logic signed [HEIGHT_W-1:0]     i_height,
    output t_out                           o_data
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int LW = $clog2(MAX_WIDTH + 1);

    logic [XW-1:0]     r_x;
    logic [LW-1:0]     r_len;
    logic signed [15:0] r_h, r_left, r_up, r_c, r_right;
    logic [15:0]       r_row;
    logic              r_fl, r_sel, r_last;
    logic signed [16:0] r_dx, r_dy;
    logic [31:0]       r_sqx, r_sqy;
    logic [33:0]       r_sum;
    logic [33:0]       r_rem  [3];
    logic              r_lsb  [3];
    logic [31:0]       r_q    [3];
    logic [16:0]       r_srem [3];
    logic [15:0]       r_root [3];
    t_out              r_out;

    logic [XW-1:0]  left_idx, right_idx, prv_addr, a_raddr, b_raddr;
    logic [15:0]    a_q, b_q, prv_q, cur_q;
    logic           we;
    logic [15:0]    mag_x, mag_y, mul_in;
    logic [31:0]    product;
    logic signed [15:0] up_v, down_v;
    logic [31:0]    msq   [3];
    logic [34:0]    d_shift [3];
    logic [33:0]    d_rem [3];
    logic           d_bit [3];
    logic [18:0]    s_t   [3];
    logic [18:0]    s_trial [3];
    logic [16:0]    s_rem [3];
    logic [15:0]    s_root [3];
    logic [15:0]    n_val [3];

    assign left_idx  = (r_x != '0) ? r_x - XW'(1) : '0;
    assign right_idx = ((LW'(r_x) + LW'(1)) < r_len) ? r_x + XW'(1) : r_x;

    always_comb begin
        case (i_cmd.op)
            OP_RD_CENTER: prv_addr = r_x;
            OP_RD_RIGHT:  prv_addr = right_idx;
            default:      prv_addr = left_idx;
        endcase
    end

    // store_select picks the store being filled; the other holds the row above
    assign a_raddr = r_sel ? prv_addr : r_x;
    assign b_raddr = r_sel ? r_x : prv_addr;
    assign prv_q   = r_sel ? a_q : b_q;
    assign cur_q   = r_sel ? b_q : a_q;
    assign we      = (i_cmd.op == OP_RD_RIGHT) && !r_fl;

    hnm_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (we && !r_sel),
        .i_waddr (r_x),
        .i_wdata (r_h),
        .i_raddr (a_raddr),
        .o_rdata (a_q)
    );

    hnm_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (we && r_sel),
        .i_waddr (r_x),
        .i_wdata (r_h),
        .i_raddr (b_raddr),
        .o_rdata (b_q)
    );

    assign up_v   = (r_row <= 16'd1) ? r_c : r_up;
    assign down_v = r_fl ? r_c : r_h;
    assign mag_x  = r_dx[16] ? 16'(-r_dx) : r_dx[15:0];
    assign mag_y  = r_dy[16] ? 16'(-r_dy) : r_dy[15:0];
    assign mul_in = (i_cmd.op == OP_SQX) ? mag_x : mag_y;
    assign product = mul_in * mul_in;

    assign msq[0] = r_sqx;
    assign msq[1] = r_sqy;
    assign msq[2] = ONE_SQ;

    // per lane: one quotient bit of m^2 * 2^30 / sum, or one root bit of the quotient
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_shift[i] = {r_rem[i], i_cmd.first ? r_lsb[i] : 1'b0};
            d_bit[i]   = d_shift[i] >= {1'b0, r_sum};
            d_rem[i]   = d_bit[i] ? 34'(d_shift[i] - {1'b0, r_sum}) : d_shift[i][33:0];

            s_t[i]     = {i_cmd.first ? 17'd0 : r_srem[i], r_q[i][31:30]};
            s_trial[i] = {1'b0, i_cmd.first ? 16'd0 : r_root[i], 2'b01};
            s_root[i]  = {i_cmd.first ? 15'd0 : r_root[i][14:0], s_t[i] >= s_trial[i]};
            s_rem[i]   = (s_t[i] >= s_trial[i]) ? 17'(s_t[i] - s_trial[i]) : s_t[i][16:0];

            n_val[i]   = 16'((17'(r_root[i]) + 17'd1) >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_x    <= i_x;
                r_len  <= i_len;
                r_h    <= i_height;
                r_row  <= i_cmd.row;
                r_fl   <= i_cmd.fl;
                r_sel  <= i_cmd.sel;
                r_last <= i_cmd.last;
            end
            OP_RD_CENTER: begin
                r_left <= prv_q;
                r_up   <= cur_q;
            end
            OP_RD_RIGHT: begin
                r_c <= prv_q;
            end
            OP_CAP_RIGHT: begin
                r_right <= prv_q;
            end
            OP_DIFF: begin
                r_dx <= 17'(r_right) - 17'(r_left);
                r_dy <= 17'(down_v) - 17'(up_v);
            end
            OP_SQX: begin
                r_sqx <= product;
            end
            OP_SQY: begin
                r_sqy <= product;
            end
            OP_SUM: begin
                r_sum <= 34'(r_sqx) + 34'(r_sqy) + 34'(ONE_SQ);
                for (int i = 0; i < 3; i++) begin
                    r_rem[i] <= 34'(msq[i] >> 1);
                    r_lsb[i] <= msq[i][0];
                    r_q[i]   <= '0;
                end
            end
            OP_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    r_rem[i] <= d_rem[i];
                    r_q[i]   <= {r_q[i][30:0], d_bit[i]};
                end
            end
            OP_SQRT: begin
                for (int i = 0; i < 3; i++) begin
                    r_srem[i] <= s_rem[i];
                    r_root[i] <= s_root[i];
                    r_q[i]    <= {r_q[i][29:0], 2'b00};
                end
            end
            OP_OUT: begin
                r_out.normal_x      <= (!r_dx[16] && r_dx != '0) ? 16'd0 - n_val[0] : n_val[0];
                r_out.normal_y      <= (!r_dy[16] && r_dy != '0) ? 16'd0 - n_val[1] : n_val[1];
                r_out.normal_z      <= n_val[2][14:0];
                r_out.column_out    <= 10'(r_x);
                r_out.row_out       <= r_row - 16'd1;
                r_out.last_of_frame <= r_last;
            end
            default: begin
            end
        endcase
    end

    assign o_data = r_out;

endmodule

// File: rtl/heightmap_normal_generator.sv
// Top level of the height map normal generator.
// Depends on hnm_pkg, hnm_ctrl and hnm_datapath (which holds two hnm_ram row stores).
//
// Input channel (i_valid/o_ready/i_data): one signed Q8.8 height per transfer,
// raster order; a flush transfer starts the end-of-frame sequence, and it and the
// row's remaining transfers finish the last row, the final one with last_of_frame.
// Output channel (o_valid/i_ready/o_data): one unit normal in Q1.14 per sample,
// with its column and row, for every sample of the row above the arriving one.
// i_cfg_wr_en/i_cfg_wr_data write row_length (saturated to 3..MAX_WIDTH). The user
// must do so only while idle; the block itself does not enforce this.
// An item is taken only while the sequencer is idle, so the next one waits until the
// last is done. An item that yields a normal runs the row store reads, the two
// squares on one multiplier and the sum, then the 31-step restoring divider and the
// 16-step square root, run in three lanes for x, y and z; a first-row item only
// fills the store. A stalled receiver holds the result in the output register; the
// next item is accepted and computed meanwhile, and waits in its last step until
// the register frees. Reset returns position, flush state and row_length (1024, or
// MAX_WIDTH if smaller) to their reset values; the row stores are not cleared.
module heightmap_normal_generator
    import hnm_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in              i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output t_out             o_data,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data
);

    t_cmd                           cmd;
    logic [$clog2(MAX_WIDTH)-1:0]   x;
    logic [$clog2(MAX_WIDTH+1)-1:0] len;

    hnm_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_flush       (i_data.flush),
        .o_ready       (o_ready),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cmd         (cmd),
        .o_x           (x),
        .o_len         (len)
    );

    hnm_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .i_x      (x),
        .i_len    (len),
        .i_height (i_data.height),
        .o_data   (o_data)
    );

endmodule

// File: tb/tb_heightmap_normal_generator.sv
// Self-checking testbench of heightmap_normal_generator: drives height maps and flush
// sequences, predicts each unit normal in Q1.14 and checks it field by field.
// Depends on hnm_pkg and the RTL of the block.
module tb_heightmap_normal_generator;
    import hnm_pkg::*;

    localparam int MAXW      = 1024;
    localparam int LATENCY   = 70;
    localparam int STALL_LIM = 4000;
    localparam int N_RAND    = 600;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    t_in              i_data = '0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    t_out             o_data;
    logic             i_cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] i_cfg_wr_data = '0;

    heightmap_normal_generator #(.MAX_WIDTH(MAXW)) dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data,
        .o_valid, .i_ready, .o_data, .i_cfg_wr_en, .i_cfg_wr_data
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // predictor state
    logic [15:0] hist_a [MAXW];
    logic [15:0] hist_b [MAXW];
    bit          m_sel;
    int          m_col;
    int          m_row;
    bit          m_flushing;
    int          m_len = 1024;

    t_in  height_q [$];
    t_out normal_q [$];
    int   errors = 0;
    int   n_normals = 0;
    int   idle_mode = 0;   // 0: sender 21 / receiver 66, 1: swapped, 2: none
    int   stall_cnt = 0;

    function automatic logic [15:0] unit_q14(longint unsigned mag, longint unsigned sum);
        longint unsigned rhs, t;
        int lo, hi, mid;
        rhs = (mag * mag) << 30;
        lo = 0;
        hi = 16384;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t = 64'(2 * mid - 1);
            if (t * t * sum <= rhs) lo = mid; else hi = mid - 1;
        end
        return lo[15:0];
    endfunction

    function automatic logic [15:0] slope_comp(int d, longint unsigned sum);
        logic [15:0] n;
        n = unit_q14(64'(d < 0 ? -d : d), sum);
        return (d > 0) ? -n : n;
    endfunction

    function automatic int rd_prev(int idx);
        return m_sel ? $signed(hist_a[idx]) : $signed(hist_b[idx]);
    endfunction

    task automatic predict_normal(t_in item);
        int x, r, c, left, right, up, down, dx, dy;
        bit fl, last;
        longint unsigned sum;
        logic [15:0] nz;
        t_out res;
        x = m_col;
        r = m_row;
        fl = item.flush || m_flushing;
        last = 1'b0;
        if (x >= MAXW) x = MAXW - 1;
        if (fl && r == 0) begin
            m_col = 0;
            m_row = 0;
            m_sel = 0;
            m_flushing = 0;
            return;
        end
        if (fl) m_flushing = 1;
        c = rd_prev(x);
        left = rd_prev(x > 0 ? x - 1 : 0);
        right = rd_prev((x + 1 < m_len) ? x + 1 : x);
        up = (r <= 1) ? c : (m_sel ? $signed(hist_b[x]) : $signed(hist_a[x]));
        if (fl) begin
            down = c;
        end else begin
            down = item.height;
            if (m_sel) hist_b[x] = item.height; else hist_a[x] = item.height;
        end
        if (x + 1 >= m_len) begin
            m_col = 0;
            if (fl) begin
                last = 1'b1;
                m_row = 0;
                m_sel = 0;
                m_flushing = 0;
            end else begin
                m_sel = ~m_sel;
                if (m_row < 65535) m_row++;
            end
        end else begin
            m_col = x + 1;
        end
        if (!fl && r == 0) return;
        dx = right - left;
        dy = down - up;
        sum = longint'(dx) * dx + longint'(dy) * dy + 262144;
        nz = unit_q14(64'd512, sum);
        res.normal_x = slope_comp(dx, sum);
        res.normal_y = slope_comp(dy, sum);
        res.normal_z = nz[14:0];
        res.column_out = x[9:0];
        res.row_out = 16'(r - 1);
        res.last_of_frame = last;
        normal_q.push_back(res);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d, want %0d (normal %0d)", what, got, want, n_normals);
        errors++;
    endtask

    // driver: advance the pending queue on every transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            int pct;
            bit moved;
            moved = i_valid && o_ready;
            if (moved) predict_normal(i_data);
            if (!i_valid || moved) begin
                pct = (idle_mode == 0) ? 21 : (idle_mode == 1) ? 66 : 0;
                if (height_q.size() > 0 && $urandom_range(0, 99) >= pct) begin
                    i_valid <= 1'b1;
                    i_data <= height_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with one long hold-off so the input backs up
    int  hold_cnt = 0;
    bit  held = 0;
    always @(posedge i_clk) begin
        int pct;
        if (!held && n_normals >= 100 && height_q.size() > 4) begin
            held = 1;
            hold_cnt = 600;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_ready <= 1'b0;
        end else begin
            pct = (idle_mode == 0) ? 66 : (idle_mode == 1) ? 21 : 0;
            i_ready <= ($urandom_range(0, 99) >= pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            t_out want;
            n_normals++;
            if (normal_q.size() == 0) begin
                $display("unexpected normal at row %0d column %0d",
                         o_data.row_out, o_data.column_out);
                errors++;
            end else begin
                want = normal_q.pop_front();
                if (o_data.normal_x !== want.normal_x)
                    report_mismatch("normal_x", o_data.normal_x, want.normal_x);
                if (o_data.normal_y !== want.normal_y)
                    report_mismatch("normal_y", o_data.normal_y, want.normal_y);
                if (o_data.normal_z !== want.normal_z)
                    report_mismatch("normal_z", o_data.normal_z, want.normal_z);
                if (o_data.column_out !== want.column_out)
                    report_mismatch("column_out", o_data.column_out, want.column_out);
                if (o_data.row_out !== want.row_out)
                    report_mismatch("row_out", o_data.row_out, want.row_out);
                if (o_data.last_of_frame !== want.last_of_frame)
                    report_mismatch("last_of_frame", o_data.last_of_frame,
                                    want.last_of_frame);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) stall_cnt <= 0;
        else stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIM) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic push_h(int h, bit fl);
        t_in it;
        it.height = h[15:0];
        it.flush = fl;
        height_q.push_back(it);
    endtask

    function automatic int rand_height();
        int k;
        k = $urandom_range(0, 3);
        if (k == 0) return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
        if (k == 3) return $signed(16'($urandom()));
        return $urandom_range(0, 1200) - 600;
    endfunction

    task automatic push_flush(int n);
        for (int i = 0; i < n; i++) push_h(rand_height(), (i == 0) ? 1'b1 : 1'($urandom()));
    endtask

    // rows complete rows, then part samples of a partial row, then the flush run
    task automatic push_frame(int len, int rows, int part);
        for (int i = 0; i < rows * len + part; i++) push_h(rand_height(), 1'b0);
        if (rows == 0) push_flush(1);
        else push_flush(len - part);
    endtask

    task automatic wait_idle();
        while (height_q.size() > 0 || i_valid || normal_q.size() > 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_len(int v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        m_len = (v < 3) ? 3 : (v > MAXW) ? MAXW : v;
    endtask

    initial begin
        int n_rand, len, rows, part;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // part of a first row at the reset length, flush with nothing complete
        for (int i = 0; i < 200; i++) push_h(rand_height(), 0);
        push_flush(1);
        wait_idle();

        // narrowest rows with extreme slopes; flush bit ignored once flushing
        write_len(0);
        push_h(-32768, 0); push_h(32767, 0); push_h(-32768, 0);
        push_h(32767, 0);  push_h(-32768, 0); push_h(32767, 0);
        push_h(0, 0);      push_h(0, 0);      push_h(0, 0);
        push_h(5, 1);      push_h(-7, 0);     push_h(9, 1);
        wait_idle();

        // saturate high, then shorten the row mid-frame; end on a partial row
        write_len(2047);
        for (int i = 0; i < 4; i++) push_h(rand_height(), 0);
        wait_idle();
        write_len(4);
        for (int i = 0; i < 7; i++) push_h(rand_height(), 0);
        push_flush(2);
        wait_idle();

        // shorten from 8 to 4 with the column already past the new end
        write_len(8);
        for (int i = 0; i < 21; i++) push_h(rand_height(), 0);
        wait_idle();
        write_len(1027);
        write_len(4);
        for (int i = 0; i < 5; i++) push_h(rand_height(), 0);
        push_flush(4);
        wait_idle();

        n_rand = 0;
        while (n_rand < N_RAND) begin
            idle_mode = n_rand * 3 / N_RAND;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(3, 12);
            rows = $urandom_range(1, 5);
            part = ($urandom_range(0, 4) == 0) ? $urandom_range(1, len - 1) : 0;
            write_len(len);
            if ($urandom_range(0, 7) == 0) push_flush(1);
            push_frame(len, rows, part);
            n_rand += (rows + 1) * len;
            wait_idle();
        end

        if (errors == 0 && normal_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/hnm_pkg.sv
rtl/hnm_ram.sv
rtl/hnm_ctrl.sv
rtl/hnm_datapath.sv
rtl/heightmap_normal_generator.sv
tb/tb_heightmap_normal_generator.sv
